### src/ffba_pkg.sv
// shared widths, codes and control structs for the first-fit block allocator
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int ADDR_W = 21;
    localparam int MODE_W = 2;
    localparam int ST_W   = 3;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESIZE  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_NULL    = 3'd1;
    localparam logic [ST_W-1:0] ST_HEAP    = 3'd2;
    localparam logic [ST_W-1:0] ST_TABLE   = 3'd3;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic            load_req;
        logic            scan_start;
        logic            scan_fit;    // kind of the scan being started
        logic            scan_run;
        logic            take;        // claim the free block hit by the fit scan
        logic            append;
        logic            release_blk;
        logic            res_set;
        logic            res_keep;    // result address is the request's user address
        logic [ST_W-1:0] res_st;
        logic            out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              size_zero;
        logic              addr_zero;
        logic              scan_done;
        logic              scan_hit;
        logic              fit_ok;
        logic              append_ok;
        logic              out_free;
    } t_sts;

endpackage

### src/first_fit_block_allocator_top.sv
// top level of the first-fit block allocator
//
// request channel: i_valid / o_stall with i_mode, i_req_size, i_user_addr.
// a request transfers when i_valid is high and o_stall is low; o_stall is
// low only while the block is idle, so one request is in work at a time.
// result channel: o_valid / i_stall with o_result_addr, o_status, one result
// per request, held in an output register until it transfers.
// work per request: a scan over the block table reads one entry a cycle from
// the single read port.
//   allocate: fit scan, append if no free block fits, response
//   release:  lookup scan, update, response
//   resize:   lookup, fit, append, free
//   null or invalid requests: response only
// a new request is taken the cycle after the result is loaded, even while
// that result is still stalled downstream; a second result waits in the block
// until the output register frees.
// reset clears the block count and break; table contents are left as is and
// only entries below the count are ever read, so no clearing pass is needed.
`timescale 1ns / 1ps

module first_fit_block_allocator_top #(
    parameter int HEAP_BYTES   = 1048576,
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [ffba_pkg::MODE_W-1:0]  i_mode,
    input  logic [ffba_pkg::ADDR_W-1:0]  i_req_size,
    input  logic [ffba_pkg::ADDR_W-1:0]  i_user_addr,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [ffba_pkg::ADDR_W-1:0]  o_result_addr,
    output logic [ffba_pkg::ST_W-1:0]    o_status
);

    ffba_pkg::t_cmd cmd;
    ffba_pkg::t_sts sts;

    ffba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ffba_datapath #(
        .HEAP_BYTES   (HEAP_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_mode        (i_mode),
        .i_req_size    (i_req_size),
        .i_user_addr   (i_user_addr),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_result_addr (o_result_addr),
        .o_status      (o_status)
    );

endmodule

### src/ffba_datapath.sv
// block table memories, break and count registers, scan pipeline and result registers
`timescale 1ns / 1ps

module ffba_datapath #(
    parameter int HEAP_BYTES   = 1048576,
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ffba_pkg::t_cmd               i_cmd,
    output ffba_pkg::t_sts               o_sts,
    input  logic [ffba_pkg::MODE_W-1:0]  i_mode,
    input  logic [ffba_pkg::ADDR_W-1:0]  i_req_size,
    input  logic [ffba_pkg::ADDR_W-1:0]  i_user_addr,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic [ffba_pkg::ADDR_W-1:0]  o_result_addr,
    output logic [ffba_pkg::ST_W-1:0]    o_status
);

    localparam int AW    = ffba_pkg::ADDR_W;
    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int BRK_W = $clog2(HEAP_BYTES + 1);
    localparam int SUM_W = ((BRK_W > AW) ? BRK_W : AW) + 2;

    localparam logic [SUM_W-1:0] HDR_S = SUM_W'(HEADER_BYTES);
    localparam logic [SUM_W-1:0] HEAP_S = SUM_W'(HEAP_BYTES);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_BLOCKS);

    logic [BRK_W-1:0] mem_start [MAX_BLOCKS];
    logic [AW-1:0]    mem_bytes [MAX_BLOCKS];
    logic             mem_free  [MAX_BLOCKS];

    logic [ffba_pkg::MODE_W-1:0] r_mode;
    logic [AW-1:0]    r_size;
    logic [AW-1:0]    r_uaddr;
    logic [CNT_W-1:0] r_count;
    logic [BRK_W-1:0] r_break;
    logic [CNT_W-1:0] r_ptr;
    logic             r_fit_kind;
    logic             r_chk_vld;
    logic [IDX_W-1:0] r_chk_idx;
    logic [BRK_W-1:0] r_rd_start;
    logic [AW-1:0]    r_rd_bytes;
    logic             r_rd_free;
    logic [IDX_W-1:0] r_fidx;
    logic [BRK_W-1:0] r_fstart;
    logic [AW-1:0]    r_res_addr;
    logic [ffba_pkg::ST_W-1:0] r_res_st;
    logic             r_out_vld;
    logic [AW-1:0]    r_out_addr;
    logic [ffba_pkg::ST_W-1:0] r_out_st;

    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] cnt_idx;
    logic             find_m;
    logic             fit_m;
    logic             hit;
    logic [SUM_W-1:0] append_sum;
    logic             heap_ovf;
    logic             tbl_full;
    logic             append_ok;
    logic             rel_last;
    logic [AW-1:0]    take_addr;
    logic [AW-1:0]    app_addr;

    assign rd_en   = i_cmd.scan_run && !i_cmd.scan_start && (r_ptr < r_count);
    assign rd_idx  = r_ptr[IDX_W-1:0];
    assign cnt_idx = r_count[IDX_W-1:0];

    assign find_m = (SUM_W'(r_rd_start) + HDR_S) == SUM_W'(r_uaddr);
    assign fit_m  = r_rd_free && (r_rd_bytes >= r_size);
    assign hit    = r_chk_vld && (r_fit_kind ? fit_m : find_m);

    assign append_sum = SUM_W'(r_break) + HDR_S + SUM_W'(r_size);
    assign heap_ovf   = append_sum > HEAP_S;
    assign tbl_full   = r_count >= MAX_C;
    assign append_ok  = !heap_ovf && !tbl_full;
    assign rel_last   = (CNT_W'(r_fidx) + CNT_W'(1)) == r_count;
    assign take_addr  = AW'(SUM_W'(r_rd_start) + HDR_S);
    assign app_addr   = AW'(SUM_W'(r_break) + HDR_S);

    always_comb begin
        o_sts.mode      = r_mode;
        o_sts.size_zero = (r_size == '0);
        o_sts.addr_zero = (r_uaddr == '0);
        o_sts.scan_hit  = hit;
        o_sts.scan_done = hit || (!r_chk_vld && (r_ptr >= r_count));
        // size of the entry being checked, valid in the lookup hit cycle
        o_sts.fit_ok    = r_rd_bytes >= r_size;
        o_sts.append_ok = append_ok;
        o_sts.out_free  = !r_out_vld || !i_out_stall;
    end

    // table memories: one read port for the scan, one write port
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_start <= mem_start[rd_idx];
            r_rd_bytes <= mem_bytes[rd_idx];
            r_rd_free  <= mem_free[rd_idx];
        end
        if (i_cmd.append && append_ok) begin
            mem_start[cnt_idx] <= r_break;
            mem_bytes[cnt_idx] <= r_size;
        end
        if (i_cmd.take) begin
            mem_free[r_chk_idx] <= 1'b0;
        end else if (i_cmd.append && append_ok) begin
            mem_free[cnt_idx] <= 1'b0;
        end else if (i_cmd.release_blk && !rel_last) begin
            mem_free[r_fidx] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_mode  <= i_mode;
            r_size  <= i_req_size;
            r_uaddr <= i_user_addr;
        end
        if (i_cmd.scan_start) begin
            r_fit_kind <= i_cmd.scan_fit;
        end
        if (rd_en) begin
            r_chk_idx <= rd_idx;
        end
        if (i_cmd.scan_run && hit && !r_fit_kind) begin
            r_fidx   <= r_chk_idx;
            r_fstart <= r_rd_start;
        end
        if (i_cmd.res_set) begin
            r_res_addr <= i_cmd.res_keep ? r_uaddr : '0;
            r_res_st   <= i_cmd.res_st;
        end else if (i_cmd.take) begin
            r_res_addr <= take_addr;
            r_res_st   <= ffba_pkg::ST_OK;
        end else if (i_cmd.append) begin
            r_res_addr <= append_ok ? app_addr : '0;
            r_res_st   <= heap_ovf ? ffba_pkg::ST_HEAP :
                          tbl_full ? ffba_pkg::ST_TABLE : ffba_pkg::ST_OK;
        end
        if (i_cmd.out_load) begin
            r_out_addr <= r_res_addr;
            r_out_st   <= r_res_st;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_break   <= '0;
            r_ptr     <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_ptr     <= '0;
                r_chk_vld <= 1'b0;
            end else begin
                if (rd_en) begin
                    r_ptr <= r_ptr + CNT_W'(1);
                end
                r_chk_vld <= rd_en;
            end
            if (i_cmd.append && append_ok) begin
                r_count <= r_count + CNT_W'(1);
                r_break <= BRK_W'(append_sum);
            end else if (i_cmd.release_blk && rel_last) begin
                r_count <= r_count - CNT_W'(1);
                r_break <= r_fstart;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_result_addr = r_out_addr;
    assign o_status      = r_out_st;

endmodule

### src/ffba_ctrl.sv
// sequencing state machine for allocate, release and resize requests
`timescale 1ns / 1ps

module ffba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  ffba_pkg::t_sts i_sts,
    output ffba_pkg::t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DISP   = 7'b0000010,
        S_FIND   = 7'b0000100,
        S_FIT    = 7'b0001000,
        S_APPEND = 7'b0010000,
        S_REL    = 7'b0100000,
        S_RESP   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   resize_old;

    // a resize with a real old block frees it after the new grant
    assign resize_old = (i_sts.mode == ffba_pkg::MODE_RESIZE) && !i_sts.addr_zero;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.res_st = ffba_pkg::ST_NULL;
                case (i_sts.mode)
                    ffba_pkg::MODE_ALLOC: begin
                        if (i_sts.size_zero) begin
                            o_cmd.res_set = 1'b1;
                            n_state       = S_RESP;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_fit   = 1'b1;
                            n_state          = S_FIT;
                        end
                    end
                    ffba_pkg::MODE_RELEASE: begin
                        if (i_sts.addr_zero) begin
                            o_cmd.res_set = 1'b1;
                            n_state       = S_RESP;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_FIND;
                        end
                    end
                    ffba_pkg::MODE_RESIZE: begin
                        if (i_sts.size_zero) begin
                            o_cmd.res_set = 1'b1;
                            n_state       = S_RESP;
                        end else if (i_sts.addr_zero) begin
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_fit   = 1'b1;
                            n_state          = S_FIT;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_FIND;
                        end
                    end
                    default: begin
                        o_cmd.res_set = 1'b1;
                        n_state       = S_RESP;
                    end
                endcase
            end
            S_FIND: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_hit) begin
                    if (i_sts.mode == ffba_pkg::MODE_RELEASE) begin
                        n_state = S_REL;
                    end else if (i_sts.fit_ok) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_keep = 1'b1;
                        o_cmd.res_st   = ffba_pkg::ST_OK;
                        n_state        = S_RESP;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        o_cmd.scan_fit   = 1'b1;
                        n_state          = S_FIT;
                    end
                end else if (i_sts.scan_done) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_st  = ffba_pkg::ST_UNKNOWN;
                    n_state       = S_RESP;
                end
            end
            S_FIT: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_hit) begin
                    o_cmd.take = 1'b1;
                    n_state    = resize_old ? S_REL : S_RESP;
                end else if (i_sts.scan_done) begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = (i_sts.append_ok && resize_old) ? S_REL : S_RESP;
            end
            S_REL: begin
                o_cmd.release_blk = 1'b1;
                if (i_sts.mode == ffba_pkg::MODE_RELEASE) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_st  = ffba_pkg::ST_OK;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
